>>> rtl/core/kmsc_pkg.sv
// Shared types and constants of the key matrix scanner.
package kmsc_pkg;

  localparam int unsigned ROW_FIELD_W = 8;
  localparam int unsigned KEY_COL_W   = 4;
  localparam int unsigned KEY_ROW_W   = 3;

  typedef struct packed {
    logic load;
    logic pop;
  } kmsc_cmd_t;

  typedef struct packed {
    logic has_change;
    logic last;
  } kmsc_sts_t;

endpackage

>>> rtl/core/key_matrix_scan_change_detect.sv
// Top level of the key matrix scanner with change detection.
//
// Input channel (in_valid_i/in_ready_o, row_bits_i): one beat per scanned
// column, holding the row bits sampled while that column is driven.
// Columns advance 0..COLS-1 and wrap; only rows below ROWS are used.
// Output channel (out_valid_o/out_ready_i): one beat per changed key, in
// ascending row order, carrying column, row, new state and a last flag
// on the final beat of the sample.
// The first change beat is visible the cycle after the sample is
// taken. A sample with k changes (k up to 8) keeps the block busy until
// its k beats are taken; a sample with no change leaves it ready.
// The change beats come one per cycle from the pending-change mask unless the receiver stalls.
// The next sample is taken only after the last beat of the previous one.
// Reset clears the column counter and the stored row bits (all released).
// A receiver stall holds the current beat and all later beats in place.
module key_matrix_scan_change_detect #(
  parameter int unsigned COLS = 16,
  parameter int unsigned ROWS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [kmsc_pkg::ROW_FIELD_W-1:0] row_bits_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kmsc_pkg::KEY_COL_W-1:0]   key_column_o,
  output logic [kmsc_pkg::KEY_ROW_W-1:0]   key_row_o,
  output logic                             pressed_o,
  output logic                             last_event_o
);
  import kmsc_pkg::*;

  kmsc_cmd_t cmd;
  kmsc_sts_t sts;

  kmsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kmsc_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .row_bits_i   (row_bits_i),
    .key_column_o (key_column_o),
    .key_row_o    (key_row_o),
    .pressed_o    (pressed_o),
    .last_event_o (last_event_o)
  );

endmodule

>>> rtl/core/kmsc_datapath.sv
// Datapath: column counter, previous-row store and pending change mask.
module kmsc_datapath #(
  parameter int unsigned COLS = 16,
  parameter int unsigned ROWS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kmsc_pkg::kmsc_cmd_t                 cmd_i,
  output kmsc_pkg::kmsc_sts_t                 sts_o,
  input  logic [kmsc_pkg::ROW_FIELD_W-1:0]    row_bits_i,
  output logic [kmsc_pkg::KEY_COL_W-1:0]      key_column_o,
  output logic [kmsc_pkg::KEY_ROW_W-1:0]      key_row_o,
  output logic                                pressed_o,
  output logic                                last_event_o
);
  import kmsc_pkg::*;

  localparam int unsigned COL_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam logic [ROW_FIELD_W-1:0] ROW_MASK =
    (ROWS >= ROW_FIELD_W) ? {ROW_FIELD_W{1'b1}} : ROW_FIELD_W'((1 << ROWS) - 1);

  logic [COL_W-1:0]       col_q, col_d;
  logic [COL_W-1:0]       ev_col_q;
  logic [ROW_FIELD_W-1:0] prev_q [COLS];
  logic [ROW_FIELD_W-1:0] now_q;
  logic [ROW_FIELD_W-1:0] pend_q, pend_d;
  logic [ROW_FIELD_W-1:0] now_bits;
  logic [ROW_FIELD_W-1:0] changes;
  logic [KEY_ROW_W-1:0]   row_sel;

  assign now_bits = row_bits_i & ROW_MASK;
  assign changes  = now_bits ^ prev_q[col_q];
  assign col_d    = (col_q == COL_W'(COLS - 1)) ? '0 : col_q + COL_W'(1);

  always_comb begin
    row_sel = '0;
    for (int i = ROW_FIELD_W - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        row_sel = KEY_ROW_W'(i);
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (cmd_i.load) begin
      pend_d = changes;
    end else if (cmd_i.pop) begin
      pend_d = pend_q & (pend_q - ROW_FIELD_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      pend_q <= '0;
      for (int c = 0; c < COLS; c++) begin
        prev_q[c] <= '0;
      end
    end else begin
      pend_q <= pend_d;
      if (cmd_i.load) begin
        prev_q[col_q] <= now_bits;
        col_q         <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q    <= now_bits;
      ev_col_q <= col_q;
    end
  end

  assign sts_o.has_change = |changes;
  assign sts_o.last       = ((pend_q & (pend_q - ROW_FIELD_W'(1))) == '0);

  assign key_column_o = KEY_COL_W'(ev_col_q);
  assign key_row_o    = row_sel;
  assign pressed_o    = now_q[row_sel];
  assign last_event_o = sts_o.last;

  a_pop_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> pend_q != '0)
    else $error("pop with no pending change");

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> pend_q == '0)
    else $error("load while changes still pending");

  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop && sts_o.last |=> pend_q == '0)
    else $error("pending mask not empty after last beat");

endmodule

>>> rtl/core/kmsc_ctrl.sv
// Controller: accepts a sample, then hands out one change beat per cycle while the receiver is ready.
module kmsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  kmsc_pkg::kmsc_sts_t sts_i,
  output kmsc_pkg::kmsc_cmd_t cmd_o
);
  import kmsc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.has_change) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i && sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.pop   = out_valid_o && out_ready_i;

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while beats pending");

  a_hold_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  a_quiet_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load && !sts_i.has_change |=> in_ready_o)
    else $error("sample without change left block busy");

endmodule

>>> dv/key_matrix_scan_change_detect_tb.sv
// Testbench of the key matrix scanner: directed and random column samples checked per event.
`timescale 1ns / 100ps

module key_matrix_scan_change_detect_tb;
  import kmsc_pkg::*;

  localparam int unsigned COLS = 16;
  localparam int unsigned ROWS = 8;
  localparam logic [ROW_FIELD_W-1:0] LIVE_ROWS =
    (ROWS >= ROW_FIELD_W) ? '1 : ROW_FIELD_W'((1 << ROWS) - 1);
  localparam int RANDOM_SCANS = 390;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_ROWS = 20;

  typedef struct packed {
    logic [KEY_COL_W-1:0] column;
    logic [KEY_ROW_W-1:0] row;
    logic                 pressed;
    logic                 last;
  } key_event_t;

  typedef struct packed {
    logic                   typed;
    logic [ROW_FIELD_W-1:0] bits;
    logic [ROW_FIELD_W-1:0] change_mask;
  } scan_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready_o;
  logic [ROW_FIELD_W-1:0] row_bits = '0;
  logic                   out_valid_o;
  logic                   out_ready = 1'b0;
  logic [KEY_COL_W-1:0]   key_column_o;
  logic [KEY_ROW_W-1:0]   key_row_o;
  logic                   pressed_o;
  logic                   last_event_o;

  key_event_t             pending_events[$];
  logic [ROW_FIELD_W-1:0] stored_rows[COLS];
  int unsigned            scan_col;
  int                     mismatch_count = 0;
  int                     idle_cycles = 0;
  logic                   send_calm = 1'b0;
  logic                   recv_calm = 1'b0;

  scan_row_t directed_scans[DIR_ROWS] = '{
    '{1'b1, 8'hFF, 8'hFF}, '{1'b1, 8'h00, 8'h00}, '{1'b1, 8'h01, 8'h01},
    '{1'b1, 8'h80, 8'h80}, '{1'b1, 8'hAA, 8'hAA}, '{1'b1, 8'h55, 8'h55},
    '{1'b1, 8'h0F, 8'h0F}, '{1'b1, 8'hF0, 8'hF0}, '{1'b1, 8'h81, 8'h81},
    '{1'b1, 8'h7E, 8'h7E}, '{1'b1, 8'h00, 8'h00}, '{1'b1, 8'hFF, 8'hFF},
    '{1'b1, 8'h3C, 8'h3C}, '{1'b1, 8'hC3, 8'hC3}, '{1'b1, 8'h10, 8'h10},
    '{1'b1, 8'h08, 8'h08}, '{1'b1, 8'h00, 8'hFF}, '{1'b1, 8'hFF, 8'hFF},
    '{1'b0, 8'h03, 8'h00}, '{1'b0, 8'h80, 8'h00}
  };

  key_matrix_scan_change_detect #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .row_bits_i  (row_bits),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .key_column_o(key_column_o),
    .key_row_o   (key_row_o),
    .pressed_o   (pressed_o),
    .last_event_o(last_event_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_wait(input logic calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Compare a sample with the stored bits of the driven column, then store and advance.
  task automatic scan_column_update(input logic [ROW_FIELD_W-1:0] bits,
                                    output logic [KEY_COL_W-1:0] col,
                                    output logic [ROW_FIELD_W-1:0] changes);
    logic [ROW_FIELD_W-1:0] now_bits;
    now_bits = bits & LIVE_ROWS;
    col = KEY_COL_W'(scan_col);
    changes = now_bits ^ stored_rows[scan_col];
    stored_rows[scan_col] = now_bits;
    scan_col = (scan_col + 1 >= COLS) ? 0 : scan_col + 1;
  endtask

  task automatic queue_key_events(input logic [KEY_COL_W-1:0] col,
                                  input logic [ROW_FIELD_W-1:0] bits,
                                  input logic [ROW_FIELD_W-1:0] changes);
    key_event_t ev;
    int first_idx;
    first_idx = pending_events.size();
    for (int r = 0; r < ROW_FIELD_W; r++) begin
      if (changes[r]) begin
        ev.column  = col;
        ev.row     = KEY_ROW_W'(r);
        ev.pressed = bits[r] & LIVE_ROWS[r];
        ev.last    = 1'b0;
        pending_events.push_back(ev);
      end
    end
    if (pending_events.size() > first_idx)
      pending_events[pending_events.size() - 1].last = 1'b1;
  endtask

  task automatic send_scan(input logic [ROW_FIELD_W-1:0] bits, input logic typed,
                           input logic [ROW_FIELD_W-1:0] typed_mask);
    int gap;
    logic [KEY_COL_W-1:0] col;
    logic [ROW_FIELD_W-1:0] changes;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    row_bits <= bits;
    do @(posedge clk_i); while (!in_ready_o);
    scan_column_update(bits, col, changes);
    if (typed) changes = typed_mask;
    queue_key_events(col, bits, changes);
  endtask

  initial begin
    logic [ROW_FIELD_W-1:0] bits;
    scan_col = 0;
    for (int c = 0; c < COLS; c++) stored_rows[c] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_scans[i])
      send_scan(directed_scans[i].bits, directed_scans[i].typed,
                directed_scans[i].change_mask);

    for (int i = 0; i < RANDOM_SCANS; i++) begin
      if (i % 50 == 0) send_calm = ($urandom_range(0, 2) == 0);
      // hold off until every queued event has drained
      if (i % 120 == 0) begin
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk_i);
      end
      bits = stored_rows[scan_col];
      case ($urandom_range(0, 9))
        0, 1, 2, 3: bits[$urandom_range(0, ROW_FIELD_W - 1)] ^= 1'b1;
        4, 5:       bits ^= ROW_FIELD_W'($urandom & $urandom);
        6:          ;
        7:          bits = ROW_FIELD_W'($urandom);
        8:          bits = '0;
        default:    bits = '1;
      endcase
      send_scan(bits, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int stall;
    int beats;
    beats = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (beats % 32 == 0) recv_calm = ($urandom_range(0, 2) == 0);
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      beats++;
    end
  end

  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected key event: column %0d row %0d pressed %0d last %0d",
               key_column_o, key_row_o, pressed_o, last_event_o);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (key_column_o !== want.column) begin
          $error("key_column: expected %0d, actual %0d", want.column, key_column_o);
          mismatch_count++;
        end
        if (key_row_o !== want.row) begin
          $error("key_row: expected %0d, actual %0d", want.row, key_row_o);
          mismatch_count++;
        end
        if (pressed_o !== want.pressed) begin
          $error("pressed: expected %0d, actual %0d", want.pressed, pressed_o);
          mismatch_count++;
        end
        if (last_event_o !== want.last) begin
          $error("last_event: expected %0d, actual %0d", want.last, last_event_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
